// ===== hw/rtl/ray_sphere_intersect_defines.svh =====
// Assertion macros used by the ray-sphere intersection checker.
`ifndef RAY_SPHERE_INTERSECT_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rsi_pkg.sv =====
// Types and constants of the ray-sphere intersection block.
package rsi_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int InDataW  = 192;
  localparam int OutDataW = 32;

  localparam logic [30:0] RadiusReset  = 31'd65536;
  localparam logic [15:0] EpsilonReset = 16'd66;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCentreX = 3'd0,
    CfgCentreY = 3'd1,
    CfgCentreZ = 3'd2,
    CfgRadius  = 3'd3,
    CfgEpsilon = 3'd4
  } cfg_idx_e;

endpackage

// ===== hw/rtl/rsi_mul.sv =====
// Four-stage signed multiplier built from 32x32 partial products.
module rsi_mul #(
  parameter int AW = 66,
  parameter int BW = 66
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int NA = (AW + 31) / 32;
  localparam int NB = (BW + 31) / 32;
  localparam int PW = AW + BW;
  localparam int SW = (NA + NB) * 32;

  logic              sg1_q, sg2_q, sg3_q;
  logic [NA*32-1:0]  ma_q;
  logic [NB*32-1:0]  mb_q;
  logic [63:0]       pp_q [NA*NB];
  logic [PW-1:0]     sum_q;
  logic [PW-1:0]     prod_q;
  logic [SW-1:0]     acc;
  logic [AW-1:0]     abs_a;
  logic [BW-1:0]     abs_b;

  assign abs_a = a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
  assign abs_b = b_i[BW-1] ? BW'(-b_i) : BW'(b_i);

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SW'(pp_q[i*NB+j]) << ((i + j) * 32));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sg1_q <= a_i[AW-1] ^ b_i[BW-1];
      ma_q  <= (NA*32)'(abs_a);
      mb_q  <= (NB*32)'(abs_b);
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i*NB+j] <= ma_q[i*32 +: 32] * mb_q[j*32 +: 32];
        end
      end
      sg2_q  <= sg1_q;
      sum_q  <= acc[PW-1:0];
      sg3_q  <= sg2_q;
      prod_q <= sg3_q ? PW'(-sum_q) : sum_q;
    end
  end

  assign p_o = $signed(prod_q);

endmodule

// ===== hw/rtl/ray_sphere_intersect.sv =====
// Ray-sphere intersection top level: Q16.16 quadratic solve, fully pipelined.
//
// A ray request enters on the s_axis channel: tdata carries dir_x, dir_y, dir_z,
// eye_x, eye_y, eye_z (32 bits each, lowest first). The sphere centre, radius
// and epsilon are set through the write port (cfg_we_i, cfg_addr_i,
// cfg_data_i) while no ray is in flight; unknown indexes are ignored.
// Each request gives one result on m_axis: tuser[0] is the hit flag, tdata the
// chosen ray parameter (zero on a miss).
// The pipeline has 131 register stages, and one request is taken per cycle
// as long as the receiver does not stall the output. Depth is set by the
// 85-step square root and the two 32-step dividers, one bit per stage.
// Reset clears all valid bits and loads the default sphere (unit radius at
// the origin, epsilon 66). When the receiver holds tready low with a result
// pending, the whole pipeline freezes and s_axis_tready drops in the same
// cycle; nothing is lost or repeated.
module ray_sphere_intersect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rsi_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  logic [rsi_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // dir_x, dir_y, dir_z, eye_x, eye_y, eye_z
  input  logic [rsi_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // hit_distance
  output logic [rsi_pkg::OutDataW-1:0]  m_axis_tdata,
  // hit
  output logic [0:0]                    m_axis_tuser
);

  localparam int SqN = 85;
  localparam int RW  = 88;
  localparam int XW  = 170;
  localparam int DvN = 32;

  logic en;

  // configuration
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [30:0]        rad_q;
  logic [15:0]        eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
      rad_q <= rsi_pkg::RadiusReset;
      eps_q <= rsi_pkg::EpsilonReset;
    end else if (cfg_we_i) begin
      unique case (rsi_pkg::cfg_idx_e'(cfg_addr_i))
        rsi_pkg::CfgCentreX: cx_q  <= $signed(cfg_data_i);
        rsi_pkg::CfgCentreY: cy_q  <= $signed(cfg_data_i);
        rsi_pkg::CfgCentreZ: cz_q  <= $signed(cfg_data_i);
        rsi_pkg::CfgRadius:  rad_q <= cfg_data_i[30:0];
        rsi_pkg::CfgEpsilon: eps_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // valid chain
  logic          v1_q, v2_q, v3_q, v94_q, v95_q, v129_q, v130_q, out_v_q;
  logic          dl_v_q [4];
  logic          sq_v_q [SqN+1];
  logic          dv_v_q [DvN+1];

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v94_q   <= 1'b0;
      v95_q   <= 1'b0;
      v129_q  <= 1'b0;
      v130_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k < 4; k++) dl_v_q[k] <= 1'b0;
      for (int k = 0; k <= SqN; k++) sq_v_q[k] <= 1'b0;
      for (int k = 0; k <= DvN; k++) dv_v_q[k] <= 1'b0;
    end else if (en) begin
      v1_q      <= s_axis_tvalid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      dl_v_q[0] <= v3_q;
      for (int k = 1; k < 4; k++) dl_v_q[k] <= dl_v_q[k-1];
      sq_v_q[0] <= dl_v_q[3];
      for (int k = 1; k <= SqN; k++) sq_v_q[k] <= sq_v_q[k-1];
      v94_q     <= sq_v_q[SqN];
      v95_q     <= v94_q;
      dv_v_q[0] <= v95_q;
      for (int k = 1; k <= DvN; k++) dv_v_q[k] <= dv_v_q[k-1];
      v129_q    <= dv_v_q[DvN];
      v130_q    <= v129_q;
      out_v_q   <= v130_q;
    end
  end

  // stage 1: direction and origin relative to centre
  logic signed [31:0] d_q [3];
  logic signed [32:0] e_q [3];
  logic signed [31:0] cen [3];

  assign cen[0] = cx_q;
  assign cen[1] = cy_q;
  assign cen[2] = cz_q;

  // stage 2: products
  logic signed [63:0] pdd_q [3];
  logic signed [64:0] pde_q [3];
  logic signed [65:0] pee_q [3];
  logic [61:0]        rr_q;

  // stage 3: quadratic coefficients
  logic [63:0]        a_q;
  logic signed [65:0] h_q;
  logic signed [66:0] c_q;

  logic signed [131:0] hh, ac;

  rsi_mul #(.AW(66), .BW(66)) u_mul_hh (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (h_q),
    .b_i   (h_q),
    .p_o   (hh)
  );

  rsi_mul #(.AW(65), .BW(67)) u_mul_ac (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   ($signed({1'b0, a_q})),
    .b_i   (c_q),
    .p_o   (ac)
  );

  logic signed [65:0] dl_h_q [4];
  logic [63:0]        dl_a_q [4];

  // discriminant
  logic signed [132:0] disc;
  logic                disc_ok;

  assign disc    = {hh[131], hh} - {ac[131], ac};
  assign disc_ok = (dl_a_q[3] != '0) && !disc[132];

  // square root, one root bit per stage
  logic [RW-1:0]      sq_rem_q  [SqN+1];
  logic [SqN-1:0]     sq_root_q [SqN+1];
  logic [XW-1:0]      sq_x_q    [SqN+1];
  logic signed [65:0] sq_h_q    [SqN+1];
  logic [63:0]        sq_a_q    [SqN+1];
  logic               sq_ok_q   [SqN+1];
  logic [RW-1:0]      sq_rem_d  [SqN];
  logic [SqN-1:0]     sq_root_d [SqN];
  logic [RW-1:0]      sq_rn     [SqN];
  logic [RW-1:0]      sq_tr     [SqN];

  always_comb begin
    for (int k = 0; k < SqN; k++) begin
      sq_rn[k] = {sq_rem_q[k][RW-3:0], sq_x_q[k][XW-1 -: 2]};
      sq_tr[k] = {1'b0, sq_root_q[k], 2'b01};
      if (sq_rn[k] >= sq_tr[k]) begin
        sq_rem_d[k]  = sq_rn[k] - sq_tr[k];
        sq_root_d[k] = {sq_root_q[k][SqN-2:0], 1'b1};
      end else begin
        sq_rem_d[k]  = sq_rn[k];
        sq_root_d[k] = {sq_root_q[k][SqN-2:0], 1'b0};
      end
    end
  end

  // numerators and their magnitudes
  logic signed [87:0] n_q   [2];
  logic [87:0]        mag_q [2];
  logic               neg_q [2];
  logic [63:0]        a94_q, a95_q;
  logic               ok94_q, ok95_q;

  // dividers, one quotient bit per stage
  logic [63:0] dv_rem_q [2][DvN+1];
  logic [31:0] dv_lo_q  [2][DvN+1];
  logic [31:0] dv_quo_q [2][DvN+1];
  logic        dv_neg_q [2][DvN+1];
  logic        dv_ovf_q [2][DvN+1];
  logic [63:0] dv_a_q   [DvN+1];
  logic        dv_ok_q  [DvN+1];
  logic [64:0] dv_r2    [2][DvN];
  logic        dv_ge    [2][DvN];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < DvN; k++) begin
        dv_r2[l][k] = {dv_rem_q[l][k], dv_lo_q[l][k][31]};
        dv_ge[l][k] = dv_r2[l][k] >= {1'b0, dv_a_q[k]};
      end
    end
  end

  // saturated roots
  logic signed [31:0] t_sat [2];
  logic [32:0]        qq    [2];
  logic               rnz   [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rnz[l] = dv_rem_q[l][DvN] != '0;
      qq[l]  = {1'b0, dv_quo_q[l][DvN]} + 33'(rnz[l]);
      if (!dv_neg_q[l][DvN]) begin
        if (dv_ovf_q[l][DvN] || dv_quo_q[l][DvN][31]) t_sat[l] = 32'sh7FFFFFFF;
        else t_sat[l] = $signed(dv_quo_q[l][DvN]);
      end else begin
        if (dv_ovf_q[l][DvN] || (qq[l] > 33'h080000000)) t_sat[l] = 32'sh80000000;
        else t_sat[l] = $signed(32'(-qq[l]));
      end
    end
  end

  logic signed [31:0] t129_q [2];
  logic               ok129_q;
  logic signed [31:0] t130_q [2];
  logic signed [63:0] prod_q;
  logic               both_q, near_q, ok130_q;
  logic signed [32:0] t2_abs;

  assign t2_abs = t129_q[1][31] ? -{t129_q[1][31], t129_q[1]} : {t129_q[1][31], t129_q[1]};

  // root choice
  logic               hit_d;
  logic signed [31:0] dist_d;
  logic               out_hit_q;
  logic signed [31:0] out_dist_q;

  always_comb begin
    hit_d  = 1'b0;
    dist_d = '0;
    if (ok130_q) begin
      if (both_q) begin
        hit_d  = 1'b1;
        dist_d = (t130_q[0] < t130_q[1]) ? t130_q[0] : t130_q[1];
      end else if (prod_q < $signed({16'd0, eps_q, 16'd0})) begin
        hit_d  = 1'b1;
        dist_d = (t130_q[0] < t130_q[1]) ? t130_q[1] : t130_q[0];
      end else if (near_q) begin
        hit_d  = 1'b1;
        dist_d = t130_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i]   <= $signed(s_axis_tdata[i*32 +: 32]);
        e_q[i]   <= $signed({s_axis_tdata[(i+3)*32+31], s_axis_tdata[(i+3)*32 +: 32]})
                    - {cen[i][31], cen[i]};
        pdd_q[i] <= d_q[i] * d_q[i];
        pde_q[i] <= d_q[i] * e_q[i];
        pee_q[i] <= e_q[i] * e_q[i];
      end
      rr_q <= rad_q * rad_q;
      a_q  <= $unsigned(pdd_q[0]) + $unsigned(pdd_q[1]) + $unsigned(pdd_q[2]);
      h_q  <= pde_q[0] + pde_q[1] + pde_q[2];
      c_q  <= pee_q[0] + pee_q[1] + pee_q[2] - $signed({5'd0, rr_q});

      dl_h_q[0] <= h_q;
      dl_a_q[0] <= a_q;
      for (int k = 1; k < 4; k++) begin
        dl_h_q[k] <= dl_h_q[k-1];
        dl_a_q[k] <= dl_a_q[k-1];
      end

      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_x_q[0]    <= disc_ok ? {6'd0, disc[131:0], 32'd0} : '0;
      sq_h_q[0]    <= dl_h_q[3];
      sq_a_q[0]    <= dl_a_q[3];
      sq_ok_q[0]   <= disc_ok;
      for (int k = 1; k <= SqN; k++) begin
        sq_rem_q[k]  <= sq_rem_d[k-1];
        sq_root_q[k] <= sq_root_d[k-1];
        sq_x_q[k]    <= sq_x_q[k-1] << 2;
        sq_h_q[k]    <= sq_h_q[k-1];
        sq_a_q[k]    <= sq_a_q[k-1];
        sq_ok_q[k]   <= sq_ok_q[k-1];
      end

      n_q[0] <= -$signed({{6{sq_h_q[SqN][65]}}, sq_h_q[SqN], 16'd0})
                + $signed({3'd0, sq_root_q[SqN]});
      n_q[1] <= -$signed({{6{sq_h_q[SqN][65]}}, sq_h_q[SqN], 16'd0})
                - $signed({3'd0, sq_root_q[SqN]});
      a94_q  <= sq_a_q[SqN];
      ok94_q <= sq_ok_q[SqN];

      for (int l = 0; l < 2; l++) begin
        neg_q[l] <= n_q[l][87];
        mag_q[l] <= n_q[l][87] ? 88'(-n_q[l]) : 88'(n_q[l]);
      end
      a95_q  <= a94_q;
      ok95_q <= ok94_q;

      dv_a_q[0]  <= a95_q;
      dv_ok_q[0] <= ok95_q;
      for (int l = 0; l < 2; l++) begin
        dv_ovf_q[l][0] <= {8'd0, mag_q[l][87:32]} >= a95_q;
        dv_rem_q[l][0] <= {8'd0, mag_q[l][87:32]};
        dv_lo_q[l][0]  <= mag_q[l][31:0];
        dv_quo_q[l][0] <= '0;
        dv_neg_q[l][0] <= neg_q[l];
      end
      for (int k = 1; k <= DvN; k++) begin
        dv_a_q[k]  <= dv_a_q[k-1];
        dv_ok_q[k] <= dv_ok_q[k-1];
        for (int l = 0; l < 2; l++) begin
          dv_rem_q[l][k] <= dv_ge[l][k-1] ? 64'(dv_r2[l][k-1] - {1'b0, dv_a_q[k-1]})
                                          : dv_r2[l][k-1][63:0];
          dv_quo_q[l][k] <= {dv_quo_q[l][k-1][30:0], dv_ge[l][k-1]};
          dv_lo_q[l][k]  <= dv_lo_q[l][k-1] << 1;
          dv_neg_q[l][k] <= dv_neg_q[l][k-1];
          dv_ovf_q[l][k] <= dv_ovf_q[l][k-1];
        end
      end

      t129_q[0] <= t_sat[0];
      t129_q[1] <= t_sat[1];
      ok129_q   <= dv_ok_q[DvN];

      t130_q[0] <= t129_q[0];
      t130_q[1] <= t129_q[1];
      prod_q    <= t129_q[0] * t129_q[1];
      both_q    <= ($signed({t129_q[0][31], t129_q[0]}) > $signed({17'd0, eps_q}))
                && ($signed({t129_q[1][31], t129_q[1]}) > $signed({17'd0, eps_q}));
      near_q    <= $unsigned(t2_abs) < {17'd0, eps_q};
      ok130_q   <= ok129_q;

      out_hit_q  <= hit_d;
      out_dist_q <= dist_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_dist_q;
  assign m_axis_tuser  = out_hit_q;

endmodule

// ===== hw/rtl/rsi_checker.sv =====
// Port-level checker for the ray-sphere intersection block, with its bind.
`include "ray_sphere_intersect_defines.svh"

module rsi_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [rsi_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input logic [rsi_pkg::CfgDataW-1:0]  cfg_data_i,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [rsi_pkg::InDataW-1:0]   s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rsi_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [0:0]                    m_axis_tuser
);

  `RSI_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "miss with nonzero distance")

  `RSI_ASSERT_NOW(a_ready_follows_out, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not track output stall")

  `RSI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);
